/* hdl/mme_pkg.sv */
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

    // Widths that the field list fixes, or the upper bounds of the parameters.
    localparam int DATA_MAX     = 32;  // widest element
    localparam int ADDR_MAX     = 8;   // store address at the largest matrix size
    localparam int DIM_MAX_BITS = 5;   // effective dimension, up to 16
    localparam int CFG_BITS     = 4;   // width of each dimension register
    localparam int CFG_IDX_BITS = 2;   // register index on the configuration port
    localparam int IDX_BITS     = 3;   // row and column fields of a result
    localparam int FRAC_BITS    = 16;  // fraction bits of Q16.16
    localparam int QUEUE_DEPTH  = 4;   // command queue between front and back

    localparam logic [CFG_BITS-1:0] DIM_RESET = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [CFG_BITS-1:0] rows_a;
        logic [CFG_BITS-1:0] inner_dim;
        logic [CFG_BITS-1:0] cols_b;
    } cfg_t;

    // One classified input item: a store write, and possibly the start of a run.
    typedef struct packed {
        logic [DATA_MAX-1:0]     data;
        logic [ADDR_MAX-1:0]     addr;
        logic                    is_a;     // write goes to the A store
        logic                    wr_en;    // slot exists
        logic                    run;      // last element of the load
        logic [DIM_MAX_BITS-1:0] rows;     // effective dimensions for the run
        logic [DIM_MAX_BITS-1:0] inner;
        logic [DIM_MAX_BITS-1:0] cols;
    } cmd_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic                last;
    } res_t;

endpackage

/* hdl/mme_ram.sv */
// Generic simple dual-port RAM with registered read.
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/mme_front.sv */
// Front end: accepts elements, tracks the load count and classifies each item.
module mme_front #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mme_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  push,
    output mme_pkg::cmd_t         push_cmd,
    input  logic                  full
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int DM     = mme_pkg::DATA_MAX;
    localparam int AM     = mme_pkg::ADDR_MAX;
    localparam int DB     = mme_pkg::DIM_MAX_BITS;

    // Zero acts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [mme_pkg::CFG_BITS-1:0] raw);
        logic [DIM_W-1:0] d;
        begin
            if (raw == '0)
                d = DIM_W'(1);
            else if (32'(raw) > MAX_DIM)
                d = DIM_W'(MAX_DIM);
            else
                d = DIM_W'(raw);
            return d;
        end
    endfunction

    logic [DIM_W-1:0]  r_dim, k_dim, c_dim;
    logic [CNT_W-1:0]  a_total, total, count_inc, b_off;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              is_a, slot_ok, run;
    logic [ADDR_W-1:0] addr;

    assign r_dim     = eff_dim(cfg.rows_a);
    assign k_dim     = eff_dim(cfg.inner_dim);
    assign c_dim     = eff_dim(cfg.cols_b);
    assign a_total   = CNT_W'(r_dim) * CNT_W'(k_dim);
    assign total     = a_total + CNT_W'(k_dim) * CNT_W'(c_dim);
    assign count_inc = count_reg + CNT_W'(1);
    assign b_off     = count_reg - a_total;
    assign is_a      = count_reg < a_total;
    assign slot_ok   = is_a || (b_off < CNT_W'(DEPTH));
    assign addr      = is_a ? ADDR_W'(count_reg) : ADDR_W'(b_off);
    assign run       = count_inc >= total;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.data  = DM'(in_data);
        push_cmd.addr  = AM'(addr);
        push_cmd.is_a  = is_a;
        push_cmd.wr_en = slot_ok;
        push_cmd.run   = run;
        push_cmd.rows  = DB'(r_dim);
        push_cmd.inner = DB'(k_dim);
        push_cmd.cols  = DB'(c_dim);
    end

    assign count_next = run ? '0 : count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/mme_fifo.sv */
// Short command queue between the front and back ends.
module mme_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mme_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output mme_pkg::cmd_t head,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mme_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/mme_back.sv */
// Back end: element stores, run sequencer and pipelined multiply-accumulate.
module mme_back #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mme_pkg::cmd_t         cmd,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [DATA_WIDTH-1:0] res_product,
    output mme_pkg::res_t         res_info
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int FRAC   = mme_pkg::FRAC_BITS;
    localparam int RES_W  = ACC_W - FRAC;
    localparam int IB     = mme_pkg::IDX_BITS;
    localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(1) << (FRAC - 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef struct packed {
        logic          first;   // first product of a sum
        logic          lastk;   // last product of a sum
        logic          endrun;  // last product of the run
        logic [IB-1:0] row;
        logic [IB-1:0] col;
    } tag_t;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  r_reg, r_next, k_reg, k_next, c_reg, c_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, t_reg, t_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next, a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_ptr_reg, b_ptr_next;
    logic              last_t, last_j, last_i;
    logic              adv, issue;
    tag_t              tag_issue;

    logic [DATA_WIDTH-1:0] a_rd, b_rd;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    tag_t                     s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_rnd;
    logic [RES_W-1:0]         rnd_q;
    logic [RES_W-DATA_WIDTH:0] rnd_hi;
    logic [DATA_WIDTH-1:0]    sat;
    logic [DATA_WIDTH-1:0]    out_prod_reg;
    mme_pkg::res_t            out_info_reg;

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_store (
        .clk     (clk),
        .wr_en   (cmd_pop && cmd.wr_en && cmd.is_a),
        .wr_addr (cmd.addr[ADDR_W-1:0]),
        .wr_data (cmd.data[DATA_WIDTH-1:0]),
        .rd_en   (issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd)
    );

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_store (
        .clk     (clk),
        .wr_en   (cmd_pop && cmd.wr_en && !cmd.is_a),
        .wr_addr (cmd.addr[ADDR_W-1:0]),
        .wr_data (cmd.data[DATA_WIDTH-1:0]),
        .rd_en   (issue),
        .rd_addr (b_ptr_reg),
        .rd_data (b_rd)
    );

    // The whole MAC pipeline moves only when the output register can take a result.
    assign adv   = !out_valid_reg || res_ready;
    assign issue = (state_reg == ST_RUN) && adv;

    assign last_t = DIM_W'(t_reg) == k_reg - DIM_W'(1);
    assign last_j = DIM_W'(j_reg) == c_reg - DIM_W'(1);
    assign last_i = DIM_W'(i_reg) == r_reg - DIM_W'(1);

    always_comb
    begin
        tag_issue.first  = t_reg == '0;
        tag_issue.lastk  = last_t;
        tag_issue.endrun = last_t && last_j && last_i;
        tag_issue.row    = IB'(i_reg);
        tag_issue.col    = IB'(j_reg);
    end

    // Sequencer: a = i*k + t, b = t*c + j, kept as running addresses.
    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        t_next      = t_reg;
        a_base_next = a_base_reg;
        a_addr_next = a_addr_reg;
        b_ptr_next  = b_ptr_reg;
        cmd_pop     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.run)
                    begin
                        state_next  = ST_RUN;
                        r_next      = cmd.rows[DIM_W-1:0];
                        k_next      = cmd.inner[DIM_W-1:0];
                        c_next      = cmd.cols[DIM_W-1:0];
                        i_next      = '0;
                        j_next      = '0;
                        t_next      = '0;
                        a_base_next = '0;
                        a_addr_next = '0;
                        b_ptr_next  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (!last_t)
                    begin
                        t_next      = t_reg + IDX_W'(1);
                        a_addr_next = a_addr_reg + ADDR_W'(1);
                        b_ptr_next  = b_ptr_reg + ADDR_W'(c_reg);
                    end
                    else
                    begin
                        t_next = '0;
                        if (!last_j)
                        begin
                            j_next      = j_reg + IDX_W'(1);
                            a_addr_next = a_base_reg;
                            b_ptr_next  = ADDR_W'(j_reg) + ADDR_W'(1);
                        end
                        else
                        begin
                            j_next      = '0;
                            b_ptr_next  = '0;
                            a_base_next = a_base_reg + ADDR_W'(k_reg);
                            a_addr_next = a_base_reg + ADDR_W'(k_reg);
                            if (last_i)
                                state_next = ST_IDLE;
                            else
                                i_next = i_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            r_reg      <= '0;
            k_reg      <= '0;
            c_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            t_reg      <= '0;
            a_base_reg <= '0;
            a_addr_reg <= '0;
            b_ptr_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            r_reg      <= r_next;
            k_reg      <= k_next;
            c_reg      <= c_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            t_reg      <= t_next;
            a_base_reg <= a_base_next;
            a_addr_reg <= a_addr_next;
            b_ptr_reg  <= b_ptr_next;
        end
    end

    // Round to nearest (ties up), drop the fraction, saturate.
    assign acc_rnd = acc_reg + RND_C;
    assign rnd_q   = acc_rnd[ACC_W-1:FRAC];
    assign rnd_hi  = rnd_q[RES_W-1:DATA_WIDTH-1];

    always_comb
    begin
        if ((&rnd_hi) || !(|rnd_hi))
            sat = rnd_q[DATA_WIDTH-1:0];
        else if (rnd_q[RES_W-1])
            sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end

    // read -> multiply -> accumulate -> round/saturate into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_tag_reg.lastk;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= tag_issue;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= $signed(a_rd) * $signed(b_rd);
            s3_tag_reg <= s2_tag_reg;
            if (s2_valid_reg)
            begin
                if (s2_tag_reg.first)
                    acc_reg <= ACC_W'(prod_reg);
                else
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            out_prod_reg      <= sat;
            out_info_reg.row  <= s3_tag_reg.row;
            out_info_reg.col  <= s3_tag_reg.col;
            out_info_reg.last <= s3_tag_reg.endrun;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_product = out_prod_reg;
    assign res_info    = out_info_reg;

    a_run_indices: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (DIM_W'(i_reg) < r_reg && DIM_W'(j_reg) < c_reg
                                   && DIM_W'(t_reg) < k_reg))
        else $error("run indices beyond dimensions");

    a_a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (a_addr_reg == a_base_reg + ADDR_W'(t_reg)))
        else $error("A address out of step with row base");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE && !cmd_empty))
        else $error("command taken outside idle or from empty queue");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(res_ready))
        else $error("result dropped without being taken");

endmodule

/* hdl/matrix_multiply_engine.sv */
// Top level of the matrix multiply engine: configuration registers and stream ports.
//
// Loads A (rows_a x inner_dim, row-major) then B (inner_dim x cols_b, row-major), one
// signed Q16.16 element per input item, and on the last B element streams out every C
// element in row-major order, rounded to nearest (ties up) and saturated to Q16.16,
// with tlast on the final one. Dimension registers of 0 act as 1 and values above
// MAX_DIM act as MAX_DIM. The front end takes one item per cycle into a 4-entry command
// queue while the queue is not full; the back end, while idle, writes the stores at one
// item per cycle, and runs each product on a single pipelined multiply-accumulate unit
// that does one step per cycle while the output is not stalled. The back end takes no
// new item from the queue until its run is through, but the front keeps filling the
// queue. A stalled output freezes the MAC pipeline. Configuration writes are always
// accepted; each element is classified with the dimensions in force when it is
// accepted, so a change in the middle of a load keeps the count. The stores need no
// clearing pass after reset; an entry read before it was ever written gives an
// unspecified value.
module matrix_multiply_engine #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [mme_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [mme_pkg::CFG_BITS-1:0]              cfg_data,
    // input elements
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]           s_axis_tdata,  // element_value
    // results
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((DATA_WIDTH+6+7)/8)*8-1:0] m_axis_tdata, // product_value, row_index, col_index
    output logic                                      m_axis_tlast   // last_of_run
);

    localparam int OUT_W = ((DATA_WIDTH + 6 + 7) / 8) * 8;

    mme_pkg::cfg_t         cfg_reg;
    mme_pkg::cmd_t         push_cmd, head;
    logic                  push, full, pop, empty;
    logic [DATA_WIDTH-1:0] res_product;
    mme_pkg::res_t         res_info;

    // Dimension registers are always writable; writes to unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_a    <= mme_pkg::DIM_RESET;
            cfg_reg.inner_dim <= mme_pkg::DIM_RESET;
            cfg_reg.cols_b    <= mme_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mme_pkg::REG_ROWS_A:    cfg_reg.rows_a    <= cfg_data;
                mme_pkg::REG_INNER_DIM: cfg_reg.inner_dim <= cfg_data;
                mme_pkg::REG_COLS_B:    cfg_reg.cols_b    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: load counting and classification of each element.
    mme_front #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata[DATA_WIDTH-1:0]),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    // Queue lets the front keep loading while a run is on the MAC.
    mme_fifo #(.DEPTH(mme_pkg::QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // Back: stores, sequencer, multiply-accumulate and output register.
    mme_back #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head),
        .cmd_empty   (empty),
        .cmd_pop     (pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_product (res_product),
        .res_info    (res_info)
    );

    assign m_axis_tdata = OUT_W'({res_info.col, res_info.row, res_product});
    assign m_axis_tlast = res_info.last;

endmodule
